>>> hw/rtl/fvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvn_pkg
// Shared constants for the fractal value noise core: octave frequencies,
// hash multipliers and the seed step between octaves.
// ============================================================================
package fvn_pkg;

    // Octave frequency 2.03^k in unsigned Q8.16, rounded to nearest.
    localparam int FREQ_W = 24;
    localparam logic [FREQ_W-1:0] FREQ_Q16 [0:7] = '{
        24'd65536,   24'd133038,  24'd270067,  24'd548237,
        24'd1112920, 24'd2259228, 24'd4586233, 24'd9310054
    };

    // Lattice corner hash constants.
    localparam logic [31:0] MUL_X     = 32'h9e3779b9;
    localparam logic [31:0] MUL_Y     = 32'h85ebca6b;
    localparam logic [31:0] MIX_A     = 32'h7feb352d;
    localparam logic [31:0] MIX_B     = 32'h846ca68b;
    localparam logic [31:0] SEED_STEP = 32'd1013;
    localparam logic [31:0] SEED_INIT = 32'd1;

    // Smoothstep term 3 * 2^16 for s = t*t*(3*2^16 - 2t) / 2^32.
    localparam logic [17:0] SMOOTH_3 = 18'h30000;

endpackage
`default_nettype wire

>>> hw/rtl/fractal_value_noise_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fractal_value_noise_core
// Path: a request runs through the chain of octave cells, the normalizer
//   and the output queue before its result reaches the master side.
// Throughput: one request per cycle when not stalled; one result per request.
// Reset: rst_n clears all valid flags and the output queue, and loads the
//   seed register with 1. There is no memory to clear.
// ============================================================================
//
// Structure
//   The datapath is a row of identical octave cells. Each cell is an
//   eight-stage pipeline: scale the coordinates by the octave frequency,
//   multiply the cell index by the hash constants, form the four corner keys
//   and the smoothstep weights, run two multiply-xorshift rounds, blend the
//   rows, blend the columns, and add the octave into the running sum. The
//   coordinates hop to the next cell after the first stage, so the running
//   sum of one cell reaches the last stage of its neighbor exactly when that
//   neighbor has its own octave value ready.
//
//   After the last cell the sum is divided by 2^OCTAVES - 1 with round to
//   nearest (reciprocal multiply plus one correction step) and saturated to
//   Q1.15. A two-entry queue holds finished results, so the pipeline keeps
//   accepting requests while a result waits to be taken. The whole pipeline
//   advances together; it only pauses when a result is ready to leave and
//   the queue already holds two.
//
// Configuration
//   cfg_we writes cfg_wdata into the seed register at the clock edge. Each
//   cell registers its octave seed from it in the following cycle.
// ============================================================================
module fractal_value_noise_core #(
    parameter int OCTAVES   = 5,
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Seed register write port.
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,      // noise_seed
    // Coordinate requests.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // [31:0] x_coord, [63:32] y_coord
    // Noise results.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [15:0]       m_axis_tdata    // [15:0] noise_value
);

    localparam int ACC_W = OCTAVES + 16;

    logic [31:0]              noise_seed_reg;
    logic                     adv;

    logic                     vld_chain [0:OCTAVES];
    logic [31:0]              x_chain   [0:OCTAVES];
    logic [31:0]              y_chain   [0:OCTAVES];
    logic signed [ACC_W-1:0]  acc_chain [0:OCTAVES];
    logic                     acc_vld   [0:OCTAVES-1];

    logic                     norm_valid;
    logic signed [15:0]       norm_value;
    logic                     buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg <= fvn_pkg::SEED_INIT;
        end
        else if (cfg_we)
        begin
            noise_seed_reg <= cfg_wdata;
        end
    end

    // Stall only when a finished result cannot enter the output queue.
    assign adv           = !(norm_valid && buf_full);
    assign s_axis_tready = adv;

    assign vld_chain[0] = s_axis_tvalid;
    assign x_chain[0]   = s_axis_tdata[31:0];
    assign y_chain[0]   = s_axis_tdata[63:32];
    assign acc_chain[0] = '0;

    for (genvar k = 0; k < OCTAVES; k++)
    begin : g_cell
        fvn_octave_cell #(
            .OCTAVES   (OCTAVES),
            .FRAC_BITS (FRAC_BITS),
            .K         (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (vld_chain[k]),
            .in_x      (x_chain[k]),
            .in_y      (y_chain[k]),
            .in_acc    (acc_chain[k]),
            .seed      (noise_seed_reg),
            .out_valid (vld_chain[k+1]),
            .out_x     (x_chain[k+1]),
            .out_y     (y_chain[k+1]),
            .acc_valid (acc_vld[k]),
            .out_acc   (acc_chain[k+1])
        );
    end

    fvn_norm #(
        .OCTAVES (OCTAVES)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (acc_vld[OCTAVES-1]),
        .in_acc    (acc_chain[OCTAVES]),
        .out_valid (norm_valid),
        .out_value (norm_value)
    );

    fvn_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv && norm_valid),
        .push_data (norm_value),
        .full      (buf_full),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata)
    );

endmodule
`default_nettype wire

>>> hw/rtl/fvn_octave_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvn_octave_cell
// One octave of value noise as an eight-stage pipeline. The coordinates
// move on to the next cell after the first stage; the weighted sum arrives
// from the previous cell just in time for the last stage.
// ============================================================================
module fvn_octave_cell #(
    parameter int OCTAVES   = 5,
    parameter int FRAC_BITS = 16,
    parameter int K         = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [31:0]                 in_x,
    input  wire logic [31:0]                 in_y,
    input  wire logic signed [OCTAVES+15:0]  in_acc,
    input  wire logic [31:0]                 seed,
    output logic                             out_valid,
    output logic [31:0]                      out_x,
    output logic [31:0]                      out_y,
    output logic                             acc_valid,
    output logic signed [OCTAVES+15:0]       out_acc
);

    localparam int ACC_W        = OCTAVES + 16;
    localparam int PROD_W       = 57;
    localparam int CELL_SHIFT   = 16 + FRAC_BITS;
    localparam int WEIGHT_SHIFT = OCTAVES - 1 - K;
    localparam int STAGES       = 8;
    localparam logic [fvn_pkg::FREQ_W-1:0] FREQ = fvn_pkg::FREQ_Q16[K];
    localparam logic [31:0] SEED_OFF = 32'(K) * fvn_pkg::SEED_STEP;

    // a + floor((b - a) * s / 2^16); the result always lies between a and b.
    function automatic logic signed [15:0] blend(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic [15:0]        s
    );
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        logic signed [17:0] sum;
        diff = 17'(b) - 17'(a);
        prod = 34'(diff) * $signed({18'd0, s});
        sum  = 18'(a) + 18'(prod >>> 16);
        return sum[15:0];
    endfunction

    logic [STAGES-1:0]         vld_reg;
    logic [31:0]               seed_k_reg;

    // Stage 1: scaled coordinates.
    logic [31:0]               x_reg, y_reg;
    logic signed [PROD_W-1:0]  px_reg, py_reg, px_next, py_next;
    // Stage 2: hash products of the cell index, smoothstep partial terms.
    logic signed [PROD_W-1:0]  pxs, pys;
    logic [15:0]               fx, fy;
    logic [31:0]               hx_reg, hy_reg, hx_next, hy_next;
    logic [31:0]               ttx_reg, tty_reg, ttx_next, tty_next;
    logic [17:0]               wx_reg, wy_reg, wx_next, wy_next;
    // Stage 3: corner keys, smoothstep weights.
    logic [49:0]               sx_prod, sy_prod;
    logic [31:0]               hx1, hy1;
    logic [31:0]               pre [4];
    logic [31:0]               v_reg [4];
    logic [31:0]               v_next [4];
    logic [15:0]               sx_d_reg [3];
    logic [15:0]               sy_d_reg [4];
    // Stages 4 and 5: multiply-xorshift rounds.
    logic [31:0]               a_reg [4];
    logic [31:0]               a_next [4];
    logic [31:0]               b_reg [4];
    logic [31:0]               b_next [4];
    // Stage 6: corner samples and the two row blends.
    logic [31:0]               h [4];
    logic signed [15:0]        smp [4];
    logic signed [15:0]        r0_reg, r1_reg, r0_next, r1_next;
    // Stage 7: column blend. Stage 8: weighted accumulation.
    logic signed [15:0]        n_reg, n_next;
    logic signed [ACC_W-1:0]   n_ext;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    always_comb
    begin
        px_next = $signed({{25{in_x[31]}}, in_x}) * $signed({33'd0, FREQ});
        py_next = $signed({{25{in_y[31]}}, in_y}) * $signed({33'd0, FREQ});

        pxs      = px_reg >>> CELL_SHIFT;
        pys      = py_reg >>> CELL_SHIFT;
        fx       = px_reg[FRAC_BITS+15 -: 16];
        fy       = py_reg[FRAC_BITS+15 -: 16];
        hx_next  = pxs[31:0] * fvn_pkg::MUL_X;
        hy_next  = pys[31:0] * fvn_pkg::MUL_Y;
        ttx_next = {16'd0, fx} * {16'd0, fx};
        tty_next = {16'd0, fy} * {16'd0, fy};
        wx_next  = fvn_pkg::SMOOTH_3 - {1'b0, fx, 1'b0};
        wy_next  = fvn_pkg::SMOOTH_3 - {1'b0, fy, 1'b0};

        sx_prod = {18'd0, ttx_reg} * {32'd0, wx_reg};
        sy_prod = {18'd0, tty_reg} * {32'd0, wy_reg};
        // The neighbor index i+1 hashes to i*M + M.
        hx1     = hx_reg + fvn_pkg::MUL_X;
        hy1     = hy_reg + fvn_pkg::MUL_Y;
        pre[0]  = hx_reg ^ hy_reg ^ seed_k_reg;
        pre[1]  = hx1    ^ hy_reg ^ seed_k_reg;
        pre[2]  = hx_reg ^ hy1    ^ seed_k_reg;
        pre[3]  = hx1    ^ hy1    ^ seed_k_reg;

        for (int i = 0; i < 4; i++)
        begin
            v_next[i] = pre[i] ^ (pre[i] >> 16);
            a_next[i] = v_reg[i] * fvn_pkg::MIX_A;
            b_next[i] = (a_reg[i] ^ (a_reg[i] >> 15)) * fvn_pkg::MIX_B;
            h[i]      = b_reg[i] ^ (b_reg[i] >> 16);
            smp[i]    = $signed({~h[i][15], h[i][14:0]});
        end

        r0_next  = blend(smp[0], smp[1], sx_d_reg[2]);
        r1_next  = blend(smp[2], smp[3], sx_d_reg[2]);
        n_next   = blend(r0_reg, r1_reg, sy_d_reg[3]);
        n_ext    = ACC_W'(n_reg);
        acc_next = in_acc + (n_ext <<< WEIGHT_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // Follows seed; the user must change seed only while idle; not enforced.
    always_ff @(posedge clk)
    begin
        seed_k_reg <= seed + SEED_OFF;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= in_x;
            y_reg       <= in_y;
            px_reg      <= px_next;
            py_reg      <= py_next;
            hx_reg      <= hx_next;
            hy_reg      <= hy_next;
            ttx_reg     <= ttx_next;
            tty_reg     <= tty_next;
            wx_reg      <= wx_next;
            wy_reg      <= wy_next;
            sx_d_reg[0] <= sx_prod[47:32];
            sy_d_reg[0] <= sy_prod[47:32];
            for (int i = 1; i < 3; i++)
            begin
                sx_d_reg[i] <= sx_d_reg[i-1];
            end
            for (int i = 1; i < 4; i++)
            begin
                sy_d_reg[i] <= sy_d_reg[i-1];
            end
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= v_next[i];
                a_reg[i] <= a_next[i];
                b_reg[i] <= b_next[i];
            end
            r0_reg  <= r0_next;
            r1_reg  <= r1_next;
            n_reg   <= n_next;
            acc_reg <= acc_next;
        end
    end

    assign out_valid = vld_reg[0];
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign acc_valid = vld_reg[STAGES-1];
    assign out_acc   = acc_reg;

endmodule
`default_nettype wire

>>> hw/rtl/fvn_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvn_norm
// Divides the weighted octave sum by 2^OCTAVES - 1, rounding to nearest,
// and saturates to Q1.15. Three stages: magnitude, reciprocal multiply,
// remainder correction.
// ============================================================================
module fvn_norm #(
    parameter int OCTAVES = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic signed [OCTAVES+15:0]  in_acc,
    output logic                             out_valid,
    output logic signed [15:0]               out_value
);

    localparam int NW     = OCTAVES + 16;
    localparam int RW     = NW + 1;
    localparam int PW     = NW + RW;
    localparam int DIV_I  = (1 << OCTAVES) - 1;
    localparam int HALF_I = DIV_I / 2;
    localparam logic [NW-1:0] DIV   = NW'(DIV_I);
    localparam logic [NW-1:0] HALF  = NW'(HALF_I);
    // floor(2^NW / DIV): the quotient estimate is low by at most one.
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << NW) / 64'(DIV_I));
    localparam logic [NW-1:0] POS_LIMIT = NW'(32767);
    localparam logic [NW-1:0] NEG_LIMIT = NW'(32768);

    logic [2:0]     vld_reg;
    logic           neg1_reg, neg2_reg;
    logic [NW-1:0]  mag1_reg, mag1_next;
    logic [NW-1:0]  mag2_reg;
    logic [PW-1:0]  prod;
    logic [NW-1:0]  q0_reg, q0_next;
    logic [NW-1:0]  rem;
    logic [NW-1:0]  q;
    logic [15:0]    value_reg, value_next;

    always_comb
    begin
        mag1_next = (in_acc[NW-1] ? NW'(-in_acc) : NW'(in_acc)) + HALF;
        prod      = PW'(mag1_reg) * PW'(RECIP);
        q0_next   = NW'(prod >> NW);
        rem       = mag2_reg - ((q0_reg << OCTAVES) - q0_reg);
        q         = (rem >= DIV) ? q0_reg + NW'(1) : q0_reg;
        if (neg2_reg)
        begin
            value_next = (q > NEG_LIMIT) ? 16'h8000 : 16'(-q);
        end
        else
        begin
            value_next = (q > POS_LIMIT) ? 16'h7fff : q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= in_acc[NW-1];
            mag1_reg  <= mag1_next;
            neg2_reg  <= neg1_reg;
            mag2_reg  <= mag1_reg;
            q0_reg    <= q0_next;
            value_reg <= value_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_value = $signed(value_reg);

endmodule
`default_nettype wire

>>> hw/rtl/fvn_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvn_out_buf
// Two-entry output queue that decouples the pipeline from the result
// consumer. Its full flag comes straight from a register.
// ============================================================================
module fvn_out_buf (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [15:0]  push_data,
    output logic              full,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [15:0]       m_data
);

    logic [15:0] mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop = m_valid && m_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full    = count_reg[1];
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

>>> test/fractal_value_noise_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// fractal_value_noise_core_test
// Self-checking bench for the fractal value noise core. A bit-exact model of
// the five-octave noise sum runs beside the block. Every accepted coordinate
// request queues the predicted noise sample. Every result taken from the
// master side is checked against the oldest queued sample. The seed register
// is swept through its extremes and through random values between phases.
// ============================================================================
module fractal_value_noise_core_test;

    // Model configuration. It matches the default parameters of the block.
    localparam int NUM_OCT   = 5;
    localparam int SEED_INC  = 1013;
    localparam int HALF_PER  = 6;
    localparam int RESET_CYC = 3;

    // Lattice hash constants.
    localparam logic [31:0] HASH_MUL_X = 32'h9e3779b9;
    localparam logic [31:0] HASH_MUL_Y = 32'h85ebca6b;
    localparam logic [31:0] HASH_MIX_A = 32'h7feb352d;
    localparam logic [31:0] HASH_MIX_B = 32'h846ca68b;

    // Run shape.
    localparam int DIRECTED_ROWS = 16;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 190;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_AT_A     = 300;
    localparam int HOLD_AT_B     = 900;
    // This drain time is generous for the last requests to come out as results.
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata = 64'd0;      // [31:0] x_coord, [63:32] y_coord
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [15:0] m_axis_tdata;              // [15:0] noise_value

    // The seed value that the model uses. Reset loads 1.
    logic [31:0] seed_model = 32'd1;
    // When set, both sides stop idling between requests.
    logic        quiet_run = 1'b0;

    logic [15:0] pending_noise [$];
    int          mismatch_count = 0;
    int          results_taken = 0;
    int          cycle_count = 0;

    fractal_value_noise_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #HALF_PER clk = ~clk;

    // ------------------------------------------------------------------------
    // Noise model
    // ------------------------------------------------------------------------

    // Octave frequency 2.03^k in unsigned Q.16, rounded to nearest.
    function automatic longint octave_freq(input int k);
        case (k)
            0:       return 65536;
            1:       return 133038;
            2:       return 270067;
            3:       return 548237;
            4:       return 1112920;
            5:       return 2259228;
            6:       return 4586233;
            default: return 9310054;
        endcase
    endfunction

    function automatic logic [31:0] hash_mix(input logic [31:0] v);
        logic [31:0] h;
        h = v ^ (v >> 16);
        h = h * HASH_MIX_A;
        h = h ^ (h >> 15);
        h = h * HASH_MIX_B;
        return h ^ (h >> 16);
    endfunction

    // Signed Q1.15 sample at one lattice corner.
    function automatic longint corner_sample(input logic [31:0] cx, input logic [31:0] cy,
                                             input logic [31:0] seed);
        logic [31:0] h;
        longint      sample;
        h = hash_mix((cx * HASH_MUL_X) ^ (cy * HASH_MUL_Y) ^ seed);
        sample = h[15:0];
        return sample - 32768;
    endfunction

    // Smoothstep weight in Q0.16.
    function automatic longint ease(input logic [15:0] t);
        longint tt;
        tt = t;
        return (tt * tt * (196608 - 2 * tt)) >>> 32;
    endfunction

    // The product fits in 64 bits, and the arithmetic shift gives the floor.
    function automatic longint lerp(input longint a, input longint b, input longint s);
        return a + (((b - a) * s) >>> 16);
    endfunction

    function automatic longint octave_value(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] seed_base, input int k);
        logic [31:0] seed_k;
        logic [31:0] ix;
        logic [31:0] iy;
        longint      xs;
        longint      ys;
        longint      px;
        longint      py;
        longint      sx;
        longint      sy;
        longint      r0;
        longint      r1;
        seed_k = seed_base + 32'(k) * 32'(SEED_INC);
        xs = $signed(x);
        ys = $signed(y);
        px = xs * octave_freq(k);
        py = ys * octave_freq(k);
        // There are 32 fraction bits after scaling. The upper word is the
        // lattice cell and wraps naturally, and the next 16 bits are t.
        ix = px[63:32];
        iy = py[63:32];
        sx = ease(px[31:16]);
        sy = ease(py[31:16]);
        r0 = lerp(corner_sample(ix, iy, seed_k), corner_sample(ix + 1, iy, seed_k), sx);
        r1 = lerp(corner_sample(ix, iy + 1, seed_k),
                  corner_sample(ix + 1, iy + 1, seed_k), sx);
        return lerp(r0, r1, sy);
    endfunction

    // Weighted sum of the octaves. The weights halve from octave to octave,
    // so the divisor is 2^NUM_OCT - 1. The divisor is odd, so the rounding
    // has no ties.
    function automatic logic [15:0] predict_noise(input logic [31:0] x, input logic [31:0] y,
                                                  input logic [31:0] seed);
        longint acc;
        longint divisor;
        longint q;
        acc = 0;
        for (int k = 0; k < NUM_OCT; k++)
            acc += octave_value(x, y, seed, k) * (longint'(1) << (NUM_OCT - 1 - k));
        divisor = (longint'(1) << NUM_OCT) - 1;
        if (acc >= 0)
            q = (acc + divisor / 2) / divisor;
        else
            q = -((-acc + divisor / 2) / divisor);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Directed coordinate pairs, packed as {y, x}. Each row is checked against
    // the model, because no row has a result that is obvious by inspection.
    function automatic logic [63:0] directed_row(input int i);
        case (i)
            0:       return {32'h00000000, 32'h00000000};  // origin
            1:       return {32'h7fffffff, 32'h7fffffff};  // most positive
            2:       return {32'h80000000, 32'h80000000};  // most negative
            3:       return {32'h7fffffff, 32'h80000000};
            4:       return {32'h80000000, 32'h7fffffff};
            5:       return {32'hffffffff, 32'hffffffff};  // cell -1, neighbor wraps to 0
            6:       return {32'h00000001, 32'h00000001};  // smallest step
            7:       return {32'h00000000, 32'h00010000};  // exact lattice point
            8:       return {32'h00008000, 32'h00008000};  // mid cell
            9:       return {32'h0000ffff, 32'h0000ffff};  // fraction at its top
            10:      return {32'h00010000, 32'hffff0000};
            11:      return {32'haaaaaaaa, 32'h55555555};
            12:      return {32'h55555555, 32'haaaaaaaa};
            13:      return {32'h7fffffff, 32'h00000000};
            14:      return {32'hfedcba98, 32'h12345678};
            default: return {32'h00000000, 32'h80000000};
        endcase
    endfunction

    // Random coordinate. The mix favors the region near the origin and the
    // edges of lattice cells, where the blending and the wrap do the most.
    function automatic logic [31:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0:       return 32'($urandom_range(0, 32'h000fffff)) - 32'h00080000;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       r[15:0] = 16'h0000;
                    1:       r[15:0] = 16'hffff;
                    2:       r[15:0] = 16'h0001;
                    default: r[15:0] = 16'h8000;
                endcase
                return r;
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7fffffff;
                    1:       return 32'h80000000;
                    2:       return 32'h00000000;
                    default: return 32'hffffffff;
                endcase
            end
            default: return r;
        endcase
    endfunction

    function automatic logic [31:0] phase_seed(input int p);
        case (p)
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            3:       return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int draw_gap();
        if (quiet_run)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // Offers one coordinate request and returns at the edge that accepts it.
    // tvalid stays high after acceptance. It drops when the next request brings
    // a gap or the sender pauses, so tvalid never gets two assignments in one step.
    task automatic send_coords(input logic [31:0] x, input logic [31:0] y);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        do @(posedge clk); while (!s_axis_tready);
        pending_noise.insert(pending_noise.size(), predict_noise(x, y, seed_model));
    endtask

    // The seed changes only while the block is empty. Every request yields a
    // result, so an empty queue means that the pipeline is idle.
    task automatic write_seed(input logic [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_noise.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        seed_model = value;
    endtask

    initial
    begin : stimulus
        logic [63:0] row;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed rows run with the seed that reset loads.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_row(i);
            send_coords(row[31:0], row[63:32]);
        end

        // Each phase pauses the sender until the block is empty, writes a
        // new seed, and then streams random coordinates.
        for (int p = 0; p < PHASES; p++)
        begin
            write_seed(phase_seed(p));
            quiet_run = (p == 2) || (p == 5);
            repeat (PHASE_ITEMS) send_coords(rand_coord(), rand_coord());
        end
        quiet_run = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Extra results that arrive during the drain are flagged by the
        // result checker.
        while (pending_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Takes results with a random stall before each one. Twice during the
    // run it holds tready low for a long stretch. The block then fills its
    // pipeline and its output queue and has to stall the coordinate side.
    initial
    begin : result_taker
        int          gap;
        logic [15:0] want;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            results_taken++;
            if (pending_noise.size() == 0)
            begin
                $error("noise_value: result %0h arrived with no request pending",
                       m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_noise.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $error("noise_value mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(m_axis_tdata));
                    mismatch_count++;
                end
            end
            if (results_taken == HOLD_AT_A || results_taken == HOLD_AT_B)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    // The slowest correct run takes far fewer cycles than this limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

>>> fractal_value_noise_core.f
hw/rtl/fvn_pkg.sv
hw/rtl/fvn_octave_cell.sv
hw/rtl/fvn_norm.sv
hw/rtl/fvn_out_buf.sv
hw/rtl/fractal_value_noise_core.sv
test/fractal_value_noise_core_test.sv
